// ----- src/bate_pkg.sv -----
`default_nettype none
package bate_pkg;

  localparam int unsigned DEPTH_DEF = 32;
  localparam int unsigned MAX_OUT   = 32;
  // count/position width that covers DEPTH up to 64
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 4;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned FILL_W = 6;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 4'd1;
  localparam logic [CMD_W-1:0] CMD_POP    = 4'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 4'd4;
  localparam logic [CMD_W-1:0] CMD_MAX    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_INSERT = 4'd6;
  localparam logic [CMD_W-1:0] CMD_DELAT  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_DELVAL = 4'd8;
  localparam logic [CMD_W-1:0] CMD_READ   = 4'd9;

  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd2;
  localparam logic [ST_W-1:0] ST_BADP  = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTF  = 3'd4;

  typedef enum logic [2:0] {
    M_HOLD, M_WRITE, M_INS, M_DEL, M_ROT
  } cell_mode_t;

  // broadcast to every cell
  typedef struct packed {
    cell_mode_t         mode;
    logic [CNT_W-1:0]   pos;
    logic [DATA_W-1:0]  wdata;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- src/bate_if.sv -----
`default_nettype none
interface bate_in_if import bate_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [POS_W-1:0]   position;
  logic signed [DATA_W-1:0] value;
  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

interface bate_out_if import bate_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ST_W-1:0]    status;
  logic [IDX_W-1:0]   index;
  logic signed [DATA_W-1:0] data;
  logic [FILL_W-1:0]  fill_count;
  logic               last;
  modport source (output valid, status, index, data, fill_count, last, input ready);
  modport sink   (input valid, status, index, data, fill_count, last, output ready);
endinterface
`default_nettype wire

// ----- src/bate_cell.sv -----
`default_nettype none
module bate_cell import bate_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [DATA_W-1:0] left_d,
  input  wire logic [DATA_W-1:0] right_d,
  input  wire logic [DATA_W-1:0] head_d,
  output logic      [DATA_W-1:0] q
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [DATA_W-1:0] q_r, q_nxt;

  always_comb begin
    q_nxt = q_r;
    unique case (ctrl.mode)
      M_HOLD: q_nxt = q_r;
      M_WRITE: begin
        if (MY_IDX == ctrl.pos) q_nxt = ctrl.wdata;
      end
      M_INS: begin
        if (MY_IDX == ctrl.pos) q_nxt = ctrl.wdata;
        else if (MY_IDX > ctrl.pos) q_nxt = left_d;
      end
      M_DEL: begin
        if (MY_IDX >= ctrl.pos) q_nxt = right_d;
      end
      M_ROT: begin
        // ring over the live entries, pos is the tail slot
        if (MY_IDX == ctrl.pos) q_nxt = head_d;
        else if (MY_IDX < ctrl.pos) q_nxt = right_d;
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule
`default_nettype wire

// ----- src/bounded_array_table_engine.sv -----
// Channel  Dir  Beat payload                               Handshake
// in_bus   in   command, position, value                   valid/ready
// out_bus  out  status, index, data, fill_count, last      valid/ready
//
// Clear, append, remove last, write, insert and delete at position finish when
// the command is accepted. Search, max, delete value and read all walk the list
// as a ring: one S_SCAN step per entry plus a closing S_FIN step, each of which
// runs only when the result register is free, so any out_bus stall holds the
// walk. rst_n is synchronous: count and control clear, cell contents stay
// undefined until written. in_bus.ready is low while a walk runs or a result
// beat still waits.
`default_nettype none
module bounded_array_table_engine import bate_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bate_in_if.sink    in_bus,
  bate_out_if.source out_bus
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] MAXO_C  = CNT_W'(MAX_OUT);

  state_t            st_r, st_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CMD_W-1:0]  op_r, op_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]  n0_r, n0_nxt;      // entries to walk
  logic [CNT_W-1:0]  t_r, t_nxt;        // walk step = original index at head
  logic [CNT_W-1:0]  k_r, k_nxt;        // search hits taken
  logic              pend_r, pend_nxt;  // a search hit held back for 'last'
  logic [IDX_W-1:0]  pidx_r, pidx_nxt;
  logic [DATA_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]  bidx_r, bidx_nxt;
  logic              hit_r, hit_nxt;

  // result register
  logic              ov_r, ov_nxt;
  logic [ST_W-1:0]   ost_r, ost_nxt;
  logic [IDX_W-1:0]  oidx_r, oidx_nxt;
  logic [DATA_W-1:0] odat_r, odat_nxt;
  logic [FILL_W-1:0] ofill_r, ofill_nxt;
  logic              olast_r, olast_nxt;

  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] cell_q [DEPTH];
  logic [DATA_W-1:0] head;
  logic              can_emit, acc, emit, match;
  logic [CNT_W-1:0]  in_pos;

  assign can_emit = !ov_r || out_bus.ready;
  assign in_bus.ready = (st_r == S_IDLE) && can_emit;
  assign acc = in_bus.valid && in_bus.ready;
  assign in_pos = CNT_W'(in_bus.position);
  assign head = cell_q[0];
  assign match = (head == val_r);

  // row of cells, each handing data to its neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] l_d, r_d;
    if (g == 0) begin : g_l0
      assign l_d = '0;
    end else begin : g_ln
      assign l_d = cell_q[g-1];
    end
    if (g == DEPTH-1) begin : g_rt
      assign r_d = '0;
    end else begin : g_rn
      assign r_d = cell_q[g+1];
    end
    bate_cell #(.IDX(g)) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .left_d (l_d),
      .right_d(r_d),
      .head_d (head),
      .q      (cell_q[g])
    );
  end

  always_comb begin
    st_nxt = st_r;   count_nxt = count_r; op_nxt = op_r;   val_nxt = val_r;
    n0_nxt = n0_r;   t_nxt = t_r;         k_nxt = k_r;     pend_nxt = pend_r;
    pidx_nxt = pidx_r; best_nxt = best_r; bidx_nxt = bidx_r; hit_nxt = hit_r;
    ctrl.mode = M_HOLD; ctrl.pos = '0; ctrl.wdata = in_bus.value;
    emit = 1'b0;
    ost_nxt = ST_OK; oidx_nxt = '0; odat_nxt = '0; olast_nxt = 1'b1;

    unique case (st_r)
      S_IDLE: begin
        if (acc) begin
          emit = 1'b1;
          case (in_bus.command) inside
            CMD_CLEAR: count_nxt = '0;
            CMD_APPEND: begin
              if (count_r >= DEPTH_C) ost_nxt = ST_FULL;
              else begin
                ctrl.mode = M_WRITE; ctrl.pos = count_r;
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_POP: begin
              if (count_r == '0) ost_nxt = ST_EMPTY;
              else count_nxt = count_r - 1'b1;
            end
            CMD_WRITE: begin
              if (in_pos >= count_r) ost_nxt = ST_BADP;
              else begin
                ctrl.mode = M_WRITE; ctrl.pos = in_pos;
              end
            end
            CMD_INSERT: begin
              if (count_r >= DEPTH_C) ost_nxt = ST_FULL;
              else if (in_pos > count_r) ost_nxt = ST_BADP;
              else begin
                ctrl.mode = M_INS; ctrl.pos = in_pos;
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_DELAT: begin
              if (in_pos >= count_r) ost_nxt = ST_BADP;
              else begin
                ctrl.mode = M_DEL; ctrl.pos = in_pos;
                count_nxt = count_r - 1'b1;
              end
            end
            CMD_SEARCH, CMD_MAX, CMD_DELVAL, CMD_READ: begin
              emit = 1'b0;
              op_nxt = in_bus.command; val_nxt = in_bus.value;
              n0_nxt = count_r; t_nxt = '0; k_nxt = '0;
              pend_nxt = 1'b0; hit_nxt = 1'b0;
              st_nxt = (count_r == '0) ? S_FIN : S_SCAN;
            end
            default: emit = 1'b0;  // unknown command: no beat
          endcase
        end
      end

      S_SCAN: begin
        if (can_emit) begin
          if (op_r == CMD_DELVAL && match) begin
            ctrl.mode = M_DEL; ctrl.pos = '0;   // drop head
            count_nxt = count_r - 1'b1;
            hit_nxt = 1'b1;
          end else begin
            ctrl.mode = M_ROT; ctrl.pos = count_r - 1'b1;
          end
          case (op_r)
            CMD_SEARCH: begin
              if (match && k_r < MAXO_C) begin
                if (pend_r) begin
                  emit = 1'b1; oidx_nxt = pidx_r; olast_nxt = 1'b0;
                end
                pend_nxt = 1'b1; pidx_nxt = t_r[IDX_W-1:0];
                k_nxt = k_r + 1'b1;
              end
            end
            CMD_MAX: begin
              if (t_r == '0 || $signed(head) > $signed(best_r)) begin
                best_nxt = head; bidx_nxt = t_r[IDX_W-1:0];
              end
            end
            CMD_READ: begin
              if (t_r < MAXO_C) begin
                emit = 1'b1;
                oidx_nxt = t_r[IDX_W-1:0]; odat_nxt = head;
                olast_nxt = (t_r == n0_r - 1'b1) || (t_r == MAXO_C - 1'b1);
              end
            end
            default: ;
          endcase
          t_nxt = t_r + 1'b1;
          if (t_r == n0_r - 1'b1) st_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (can_emit) begin
          st_nxt = S_IDLE;
          emit = 1'b1;
          case (op_r)
            CMD_SEARCH: begin
              if (pend_r) oidx_nxt = pidx_r;
              else ost_nxt = ST_NOTF;
            end
            CMD_MAX: begin
              if (n0_r == '0) ost_nxt = ST_EMPTY;
              else begin
                oidx_nxt = bidx_r; odat_nxt = best_r;
              end
            end
            CMD_DELVAL: ost_nxt = hit_r ? ST_OK : ST_NOTF;
            CMD_READ: begin
              if (n0_r == '0) ost_nxt = ST_EMPTY;
              else emit = 1'b0;   // last beat already went out
            end
            default: emit = 1'b0;
          endcase
        end
      end

      default: st_nxt = S_IDLE;
    endcase

    ofill_nxt = count_nxt[FILL_W-1:0];
    ov_nxt = emit || (ov_r && !out_bus.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;  val_r <= val_nxt;  n0_r <= n0_nxt;  t_r <= t_nxt;
    k_r <= k_nxt;    pend_r <= pend_nxt; pidx_r <= pidx_nxt;
    best_r <= best_nxt; bidx_r <= bidx_nxt; hit_r <= hit_nxt;
    if (emit) begin
      ost_r   <= ost_nxt;
      oidx_r  <= oidx_nxt;
      odat_r  <= odat_nxt;
      ofill_r <= ofill_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_bus.valid      = ov_r;
  assign out_bus.status     = ost_r;
  assign out_bus.index      = oidx_r;
  assign out_bus.data       = odat_r;
  assign out_bus.fill_count = ofill_r;
  assign out_bus.last       = olast_r;

endmodule
`default_nettype wire

// ----- src/bate_checker.sv -----
`default_nettype none
module bate_checker import bate_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [ST_W-1:0]   out_status,
  input wire logic [IDX_W-1:0]  out_index,
  input wire logic [DATA_W-1:0] out_data,
  input wire logic [FILL_W-1:0] out_fill_count,
  input wire logic              out_last
);

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last)
    else $error("error status on a non-final beat");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_index == '0 && out_data == '0)
    else $error("error beat carries index or data");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && DEPTH < 64 |-> 7'(out_fill_count) <= 7'(DEPTH))
    else $error("fill count beyond capacity");

endmodule

bind bounded_array_table_engine bate_checker #(.DEPTH(DEPTH)) u_bate_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .out_status    (out_bus.status),
  .out_index     (out_bus.index),
  .out_data      (out_bus.data),
  .out_fill_count(out_bus.fill_count),
  .out_last      (out_bus.last)
);
`default_nettype wire
